// ===== rtl/format_version_string_parser_top_macros.svh =====
// assertion macros for the version header line parser
// used by format_version_string_parser_top; no other dependencies
`ifndef FORMAT_VERSION_STRING_PARSER_TOP_MACROS_SVH
`define FORMAT_VERSION_STRING_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FVSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define FVSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/fvsp_pkg.sv =====
// shared types and constants of the version header line parser
// no dependencies
package fvsp_pkg;

    // parse phases
    localparam logic [1:0] PH_SEEK     = 2'd0;
    localparam logic [1:0] PH_TAG      = 2'd1;
    localparam logic [1:0] PH_PARTS    = 2'd2;
    localparam logic [1:0] PH_TAG_DONE = 2'd3;

    typedef logic [2:0] t_fail;

    // failure codes
    localparam t_fail FAIL_NONE      = 3'd0;
    localparam t_fail FAIL_NO_SPACE  = 3'd1;
    localparam t_fail FAIL_TAG       = 3'd2;
    localparam t_fail FAIL_RANGE     = 3'd3;
    localparam t_fail FAIL_MANY_DOTS = 3'd4;
    localparam t_fail FAIL_BAD_CHAR  = 3'd5;
    localparam t_fail FAIL_COUNT     = 3'd6;

    localparam logic [3:0] TAG_LEN   = 4'd12;
    localparam logic [8:0] PART_MAX  = 9'd255;
    localparam logic [8:0] PART_SAT  = 9'd256;
    localparam logic [1:0] LAST_PART = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // tag text "File Format " by position
    function automatic logic [7:0] tag_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h46;
            4'd1:    ch = 8'h69;
            4'd2:    ch = 8'h6C;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h20;
            4'd5:    ch = 8'h46;
            4'd6:    ch = 8'h6F;
            4'd7:    ch = 8'h72;
            4'd8:    ch = 8'h6D;
            4'd9:    ch = 8'h61;
            4'd10:   ch = 8'h74;
            4'd11:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/format_version_string_parser_top.sv =====
// version header line parser: checks "<word> File Format a.b.c.d" and packs the parts
// depends on fvsp_pkg and format_version_string_parser_top_macros.svh
//
// usage
//   slave channel: one character per transfer, tdata[7:0] is the byte,
//   tlast marks the final byte of the line.
//   master channel: one result per line, sent after the tlast byte.
//   tuser[0] is ok, tdata[31:0] the packed version (part k in byte k,
//   zero on failure), tdata[34:32] the failure code (zero when ok).
// timing
//   one character is taken every cycle while ready is high; the per-character
//   step (tag compare, multiply by ten with saturation, part packing) sits
//   between the parse state registers and is done in the cycle of the transfer.
//   the result is valid in the cycle after the tlast byte is taken.
// reset
//   synchronous active-low reset returns the parser to seeking the first
//   space and empties the result register.
// stall
//   the result register holds while the receiver is not ready, and no
//   character is taken in that time, i.e. ready is low only while a result
//   waits and the receiver is stalled.
`include "format_version_string_parser_top_macros.svh"

module format_version_string_parser_top
    import fvsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // end_of_line
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] version_word, [34:32] fail_code, zero pad
    output logic [0:0]  o_m_axis_tuser    // [0] ok
);

    // parse state
    logic [1:0]  r_phase,    n_phase;
    logic [3:0]  r_tag_pos,  n_tag_pos;
    logic [8:0]  r_part_acc, n_part_acc;
    logic [1:0]  r_part_idx, n_part_idx;
    logic [31:0] r_word,     n_word;
    t_fail       r_fail,     n_fail;

    // result register
    logic        r_out_valid;
    logic        r_out_ok;
    logic [31:0] r_out_word;
    t_fail       r_out_code;

    logic        s_in_xfer;
    logic        s_out_xfer;
    logic        s_is_digit;
    logic [11:0] s_times_ten;
    t_fail       s_code;
    logic [31:0] s_final_word;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign s_out_xfer      = r_out_valid && i_m_axis_tready;

    // digit class and accumulate step
    assign s_is_digit  = (i_s_axis_tdata >= CH_ZERO) && (i_s_axis_tdata <= CH_NINE);
    assign s_times_ten = {r_part_acc, 3'b000} + {2'b00, r_part_acc, 1'b0}
                       + {8'h00, i_s_axis_tdata[3:0]};

    // next parse state for one character
    always_comb begin
        n_phase    = r_phase;
        n_tag_pos  = r_tag_pos;
        n_part_acc = r_part_acc;
        n_part_idx = r_part_idx;
        n_word     = r_word;
        n_fail     = r_fail;
        if (r_fail == FAIL_NONE) begin
            unique case (r_phase)
                PH_SEEK: begin
                    if (i_s_axis_tdata == CH_SPACE) begin
                        n_phase   = PH_TAG;
                        n_tag_pos = 4'd0;
                    end
                end
                PH_TAG: begin
                    if (r_tag_pos >= TAG_LEN || i_s_axis_tdata != tag_char(r_tag_pos)) begin
                        n_fail = FAIL_TAG;
                    end else begin
                        n_tag_pos = r_tag_pos + 4'd1;
                        if (r_tag_pos + 4'd1 == TAG_LEN) begin
                            n_phase = PH_TAG_DONE;
                        end
                    end
                end
                default: begin
                    // tag done or gathering parts
                    n_phase = PH_PARTS;
                    if (i_s_axis_tdata == CH_DOT) begin
                        if (r_part_acc > PART_MAX) begin
                            n_fail = FAIL_RANGE;
                        end else if (r_part_idx >= LAST_PART) begin
                            n_fail = FAIL_MANY_DOTS;
                        end else begin
                            case (r_part_idx)
                                2'd0:    n_word[7:0]   = r_part_acc[7:0];
                                2'd1:    n_word[15:8]  = r_part_acc[7:0];
                                default: n_word[23:16] = r_part_acc[7:0];
                            endcase
                            n_part_idx = r_part_idx + 2'd1;
                            n_part_acc = 9'd0;
                        end
                    end else if (s_is_digit) begin
                        n_part_acc = (s_times_ten > {3'b000, PART_SAT}) ? PART_SAT
                                                                        : s_times_ten[8:0];
                    end else begin
                        n_fail = FAIL_BAD_CHAR;
                    end
                end
            endcase
        end
    end

    // judgment of the line after its last character
    always_comb begin
        s_final_word = 32'd0;
        if (n_fail != FAIL_NONE) begin
            s_code = n_fail;
        end else if (n_phase == PH_SEEK) begin
            s_code = FAIL_NO_SPACE;
        end else if (n_phase == PH_TAG || n_phase == PH_TAG_DONE) begin
            s_code = FAIL_TAG;
        end else if (n_part_idx != LAST_PART) begin
            s_code = FAIL_COUNT;
        end else if (n_part_acc > PART_MAX) begin
            s_code = FAIL_RANGE;
        end else begin
            s_code       = FAIL_NONE;
            s_final_word = {n_part_acc[7:0], n_word[23:0]};
        end
    end

    // parse state registers, back to start after each line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEEK;
            r_tag_pos  <= 4'd0;
            r_part_acc <= 9'd0;
            r_part_idx <= 2'd0;
            r_word     <= 32'd0;
            r_fail     <= FAIL_NONE;
        end else if (s_in_xfer) begin
            if (i_s_axis_tlast) begin
                r_phase    <= PH_SEEK;
                r_tag_pos  <= 4'd0;
                r_part_acc <= 9'd0;
                r_part_idx <= 2'd0;
                r_word     <= 32'd0;
                r_fail     <= FAIL_NONE;
            end else begin
                r_phase    <= n_phase;
                r_tag_pos  <= n_tag_pos;
                r_part_acc <= n_part_acc;
                r_part_idx <= n_part_idx;
                r_word     <= n_word;
                r_fail     <= n_fail;
            end
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_in_xfer && i_s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (s_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s_in_xfer && i_s_axis_tlast) begin
            r_out_ok   <= (s_code == FAIL_NONE);
            r_out_word <= s_final_word;
            r_out_code <= s_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out_code, r_out_word};
    assign o_m_axis_tuser  = r_out_ok;

    // checks
    `FVSP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        s_in_xfer && i_s_axis_tlast, o_m_axis_tvalid)
    `FVSP_ASSERT_NEXT(a_state_cleared_after_line, i_clk, i_rst_n,
        s_in_xfer && i_s_axis_tlast,
        r_phase == PH_SEEK && r_fail == FAIL_NONE && r_part_idx == 2'd0 && r_word == 32'd0)
    `FVSP_ASSERT_NEXT(a_failure_freezes_parts, i_clk, i_rst_n,
        s_in_xfer && !i_s_axis_tlast && r_fail != FAIL_NONE,
        $stable(r_part_acc) && $stable(r_part_idx) && $stable(r_fail))
    `FVSP_ASSERT_NOW(a_ok_matches_code, i_clk, i_rst_n,
        o_m_axis_tvalid, r_out_ok == (r_out_code == FAIL_NONE))

endmodule

// ===== bench/tb_top.sv =====
// testbench for format_version_string_parser_top: header lines in, parse results out
// depends on fvsp_pkg and the parser rtl; self-checking, needs no input files
`timescale 1ns / 1ps

module tb_top;
    import fvsp_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_CHARS  = 900;
    localparam int QUIET_CHARS   = 150;
    localparam int TAIL_CYCLES   = 10;
    localparam logic [8*12-1:0] TAG_TEXT = "File Format ";

    typedef struct packed {
        logic        ok;
        logic [31:0] version;
        t_fail       code;
    } t_version_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    // parser state mirrored by the predictor
    logic [1:0]  prs_phase;
    logic [3:0]  prs_tag_pos;
    logic [8:0]  prs_part;
    logic [1:0]  prs_dots;
    logic [31:0] prs_word;
    t_fail       prs_fail;

    t_version_result pending_versions[$];
    logic [7:0]      line_bytes[$];

    int  err_cnt    = 0;
    int  sent_chars = 0;
    int  quiet_cnt  = 0;
    bit  idle_on    = 1'b0;
    bit  hold_req   = 1'b0;

    format_version_string_parser_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] char_code
        .i_s_axis_tlast  (i_s_axis_tlast),   // end_of_line
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] version_word, [34:32] fail_code
        .o_m_axis_tuser  (o_m_axis_tuser)    // [0] ok
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_parse();
        prs_phase   = PH_SEEK;
        prs_tag_pos = 4'd0;
        prs_part    = 9'd0;
        prs_dots    = 2'd0;
        prs_word    = 32'd0;
        prs_fail    = FAIL_NONE;
    endfunction

    // one character of the version field: digit, dot or fault
    function automatic void take_version_char(input logic [7:0] c);
        logic [31:0] prod;
        if (c == CH_DOT) begin
            if (prs_part > PART_MAX)
                prs_fail = FAIL_RANGE;
            else if (prs_dots >= LAST_PART)
                prs_fail = FAIL_MANY_DOTS;
            else begin
                prs_word = prs_word | ({24'd0, prs_part[7:0]} << (8 * prs_dots));
                prs_dots = prs_dots + 2'd1;
                prs_part = 9'd0;
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            prod     = 32'(prs_part) * 32'd10 + 32'(c - CH_ZERO);
            prs_part = (prod > 32'(PART_SAT)) ? PART_SAT : prod[8:0];
        end else begin
            prs_fail = FAIL_BAD_CHAR;
        end
    endfunction

    // advance the predicted parser by one accepted character
    function automatic void predict_char(input logic [7:0] c, input logic eol);
        t_version_result res;
        if (prs_fail == FAIL_NONE) begin
            case (prs_phase)
                PH_SEEK: begin
                    if (c == CH_SPACE) begin
                        prs_phase   = PH_TAG;
                        prs_tag_pos = 4'd0;
                    end
                end
                PH_TAG: begin
                    if (prs_tag_pos >= TAG_LEN ||
                        c != TAG_TEXT[8 * (11 - int'(prs_tag_pos)) +: 8]) begin
                        prs_fail = FAIL_TAG;
                    end else begin
                        prs_tag_pos = prs_tag_pos + 4'd1;
                        if (prs_tag_pos == TAG_LEN)
                            prs_phase = PH_TAG_DONE;
                    end
                end
                PH_TAG_DONE: begin
                    prs_phase = PH_PARTS;
                    take_version_char(c);
                end
                default: begin
                    take_version_char(c);
                end
            endcase
        end
        if (eol) begin
            res = '0;
            if (prs_fail != FAIL_NONE)
                res.code = prs_fail;
            else if (prs_phase == PH_SEEK)
                res.code = FAIL_NO_SPACE;
            else if (prs_phase == PH_TAG || prs_phase == PH_TAG_DONE)
                res.code = FAIL_TAG;
            else if (prs_dots != LAST_PART)
                res.code = FAIL_COUNT;
            else if (prs_part > PART_MAX)
                res.code = FAIL_RANGE;
            else begin
                res.ok      = 1'b1;
                res.code    = FAIL_NONE;
                res.version = prs_word | ({24'd0, prs_part[7:0]} << 24);
            end
            pending_versions.push_back(res);
            clear_parse();
        end
    endfunction

    // one character transfer, with an optional random gap before it
    task automatic send_char(input logic [7:0] c, input logic eol);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = 8'($urandom);
            i_s_axis_tlast  = 1'($urandom);
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = c;
        i_s_axis_tlast  = eol;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_char(c, eol);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_line_bytes();
        for (int i = 0; i < line_bytes.size(); i++)
            send_char(line_bytes[i], i == line_bytes.size() - 1);
    endtask

    // sender goes quiet until every predicted result has been seen
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_versions.size() != 0) @(posedge i_clk);
    endtask

    // build one line: mostly well-formed headers with random faults, some noise
    task automatic make_line();
        int    kind;
        int    nparts;
        int    cut;
        int    bad;
        string num;
        line_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(0, 3))
                    0:       line_bytes.push_back(CH_SPACE);
                    1:       line_bytes.push_back(8'($urandom_range(CH_DOT, CH_NINE)));
                    default: line_bytes.push_back(8'($urandom));
                endcase
            end
            return;
        end
        repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom));
        line_bytes.push_back(CH_SPACE);
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 11) : -1;
        bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 11) : -1;
        for (int i = 0; i < 12; i++) begin
            if (i == cut)
                return;
            if (i == bad)
                line_bytes.push_back(8'($urandom));
            else
                line_bytes.push_back(TAG_TEXT[8 * (11 - i) +: 8]);
        end
        nparts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 4;
        for (int p = 0; p < nparts; p++) begin
            if (p != 0)
                line_bytes.push_back(CH_DOT);
            if ($urandom_range(0, 6) == 0) begin
                // raw digit run: empty parts and overflow
                repeat ($urandom_range(0, 5))
                    line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            end else begin
                if ($urandom_range(0, 7) == 0)
                    line_bytes.push_back(CH_ZERO);
                num = $sformatf("%0d", $urandom_range(0, 255));
                for (int i = 0; i < num.len(); i++)
                    line_bytes.push_back(num[i]);
            end
            if ($urandom_range(0, 24) == 0)
                line_bytes.push_back(8'($urandom));
        end
    endtask

    // special cases of the header format, one line each
    task automatic test_directed();
        send_text("v File Format 20.0.0.5");
        send_text(" File Format 255.255.255.255");
        send_text(" File Format ...");
        send_text("abc");
        send_text(" Fi");
        send_text(" File Format ");
        send_text(" File Formax 1.2.3.4");
        send_text(" File Format 256.1.2.3");
        send_text(" File Format 1.2.3.4.5");
        send_text(" File Format 1.2a.3.4");
        send_text(" File Format 0.0.0/:");
        send_text(" File Format 1.2.3");
        send_text(" File Format 1.2.999");
        send_text(" File Format 1.2.3.300");
        send_text(" File Format 300.x....");
        // extreme byte values in the leading word, then a line of one 0xFF byte
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text(" File Format 9.8.7.6");
        send_char(8'hFF, 1'b1);
        wait_drained();
    endtask

    // receiver holds off while short lines keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (24) begin
            line_bytes.delete();
            repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom));
            send_line_bytes();
        end
        wait_drained();
    endtask

    // random lines with idling on both sides and one full drain midway
    task automatic test_random_lines();
        int start;
        bit drained;
        start   = sent_chars;
        drained = 1'b0;
        idle_on = 1'b1;
        while (sent_chars - start < RANDOM_CHARS) begin
            make_line();
            send_line_bytes();
            if (!drained && sent_chars - start > RANDOM_CHARS / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        int start;
        start   = sent_chars;
        idle_on = 1'b0;
        while (sent_chars - start < QUIET_CHARS) begin
            make_line();
            send_line_bytes();
        end
    endtask

    // receiver: random stall bursts, plus a long hold when asked
    initial begin
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_version_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_versions.size() == 0) begin
                $error("unexpected result: ok=%0b version_word=%h fail_code=%0d",
                       o_m_axis_tuser[0], o_m_axis_tdata[31:0], o_m_axis_tdata[34:32]);
                err_cnt++;
            end else begin
                want = pending_versions.pop_front();
                if (o_m_axis_tuser[0] !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, o_m_axis_tuser[0]);
                    err_cnt++;
                end
                if (o_m_axis_tdata[31:0] !== want.version) begin
                    $error("version_word: expected %h, got %h",
                           want.version, o_m_axis_tdata[31:0]);
                    err_cnt++;
                end
                if (o_m_axis_tdata[34:32] !== want.code) begin
                    $error("fail_code: expected %0d, got %0d",
                           want.code, o_m_axis_tdata[34:32]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("format_version_string_parser_top verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        clear_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_lines();
        test_full_rate();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("format_version_string_parser_top verification clean");
        else
            $display("format_version_string_parser_top verification failed");
        $finish;
    end

endmodule
